>>> rtl/core/bdeu_pkg.sv
// ----------------------------------------------------------------------------
// bdeu_pkg
// Shared types and constants for the button debounce and event detector.
// ----------------------------------------------------------------------------
package bdeu_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE     = 2'd1;
  localparam logic [1:0] REG_DOUBLE_CLICK = 2'd2;
  localparam logic [1:0] REG_HOLD         = 2'd3;

  // Register reset values
  localparam logic        ACTIVE_LEVEL_RST = 1'b0;
  localparam logic [15:0] DEBOUNCE_RST     = 16'd30;
  localparam logic [15:0] DOUBLE_CLICK_RST = 16'd400;
  localparam logic [15:0] HOLD_RST         = 16'd1500;

  // Configuration register set
  typedef struct packed {
    logic        active_level;
    logic [15:0] debounce_delay;
    logic [15:0] double_click_delay;
    logic [15:0] hold_delay;
  } cfg_t;

  // One input sample
  typedef struct packed {
    logic        raw_level;
    logic [31:0] now_ms;
    logic        clear_presses;
    logic        clear_releases;
  } sample_t;

  // One result beat
  typedef struct packed {
    logic        is_pressed;
    logic        changed;
    logic        just_pressed;
    logic        just_released;
    logic        double_click;
    logic        held;
    logic        press_toggle;
    logic        release_toggle;
    logic [15:0] press_total;
    logic [15:0] release_total;
  } result_t;

endpackage

>>> rtl/core/bdeu_tracker.sv
// ----------------------------------------------------------------------------
// bdeu_tracker
// Debounce state, event detection, counters and timestamps for one sample.
// ----------------------------------------------------------------------------
module bdeu_tracker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  bdeu_pkg::sample_t sample,
  input  bdeu_pkg::cfg_t    cfg,
  output bdeu_pkg::result_t result
);

  logic        last_raw_r,      last_raw_nxt;
  logic        settled_r,       settled_nxt;
  logic        prev_stable_r,   prev_stable_nxt;
  logic        stable_r,        stable_nxt;
  logic [31:0] settle_start_r,  settle_start_nxt;
  logic [31:0] press_stamp_r,   press_stamp_nxt;
  logic [31:0] release_stamp_r, release_stamp_nxt;
  logic [15:0] press_cnt_r,     press_cnt_nxt;
  logic [15:0] release_cnt_r,   release_cnt_nxt;
  logic        press_flip_r,    press_flip_nxt;
  logic        release_flip_r,  release_flip_nxt;

  logic        raw_diff;
  logic [31:0] settle_age;
  logic [31:0] press_age;
  logic [31:0] release_gap;
  logic [15:0] press_base;
  logic [15:0] release_base;
  logic        pressed;
  logic        changed;
  logic        jp;
  logic        jr;

  // Time differences, modulo 2^32; all from the old stamps in parallel
  assign settle_age  = sample.now_ms - settle_start_r;
  assign press_age   = sample.now_ms - press_stamp_r;
  assign release_gap = sample.now_ms - release_stamp_r;

  // Debounce: raw change restarts the settle timer
  assign raw_diff = (sample.raw_level != last_raw_r);

  always_comb begin
    settle_start_nxt = raw_diff ? sample.now_ms : settle_start_r;
    if (raw_diff) begin
      settled_nxt = 1'b0;
    end else if (settle_age > {16'd0, cfg.debounce_delay}) begin
      settled_nxt = 1'b1;
    end else begin
      settled_nxt = settled_r;
    end
    last_raw_nxt = sample.raw_level;
  end

  // Stable level follows raw once settled
  assign prev_stable_nxt = settled_nxt ? stable_r : prev_stable_r;
  assign stable_nxt      = settled_nxt ? sample.raw_level : stable_r;

  assign pressed = (stable_nxt == cfg.active_level);
  assign changed = (prev_stable_nxt != stable_nxt);
  assign jp      = changed & pressed;
  assign jr      = changed & ~pressed;

  // Clears act before this sample's count
  assign press_base   = sample.clear_presses  ? 16'd0 : press_cnt_r;
  assign release_base = sample.clear_releases ? 16'd0 : release_cnt_r;

  // Event bookkeeping
  assign press_cnt_nxt     = jp ? press_base + 16'd1 : press_base;
  assign release_cnt_nxt   = jr ? release_base + 16'd1 : release_base;
  assign press_stamp_nxt   = jp ? sample.now_ms : press_stamp_r;
  assign release_stamp_nxt = jr ? sample.now_ms : release_stamp_r;
  assign press_flip_nxt    = press_flip_r ^ jp;
  assign release_flip_nxt  = release_flip_r ^ jr;

  // Result for this sample
  always_comb begin
    result.is_pressed     = pressed;
    result.changed        = changed;
    result.just_pressed   = jp;
    result.just_released  = jr;
    // interval between last two releases is now minus the older stamp
    result.double_click   = jr && (release_gap <= {16'd0, cfg.double_click_delay});
    // a press in this sample restarts the hold time at zero
    result.held           = pressed && !jp && (press_age > {16'd0, cfg.hold_delay});
    result.press_toggle   = press_flip_nxt;
    result.release_toggle = release_flip_nxt;
    result.press_total    = press_cnt_nxt;
    result.release_total  = release_cnt_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r      <= 1'b0;
      settled_r       <= 1'b1;
      prev_stable_r   <= 1'b0;
      stable_r        <= 1'b0;
      settle_start_r  <= 32'd0;
      press_stamp_r   <= 32'd0;
      release_stamp_r <= 32'd0;
      press_cnt_r     <= 16'd0;
      release_cnt_r   <= 16'd0;
      press_flip_r    <= 1'b0;
      release_flip_r  <= 1'b1;
    end else if (step_en) begin
      last_raw_r      <= last_raw_nxt;
      settled_r       <= settled_nxt;
      prev_stable_r   <= prev_stable_nxt;
      stable_r        <= stable_nxt;
      settle_start_r  <= settle_start_nxt;
      press_stamp_r   <= press_stamp_nxt;
      release_stamp_r <= release_stamp_nxt;
      press_cnt_r     <= press_cnt_nxt;
      release_cnt_r   <= release_cnt_nxt;
      press_flip_r    <= press_flip_nxt;
      release_flip_r  <= release_flip_nxt;
    end
  end

endmodule

>>> rtl/core/button_debounce_event_detector_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_event_detector_unit
// Debounces timestamped button samples and reports press, release,
// double-click and hold events with wrapping event counts.
// ----------------------------------------------------------------------------
// Each accepted sample reaches out_* when it moves into the result register.
// Throughput: one sample per cycle while out_stall is low; the input
// register feeds one pass of subtract-and-compare logic straight into the result
// register. Stalls propagate through the two registers, so no beat is dropped.
// Reset (rst_n low, synchronous): pipeline empties, configuration returns to
// its defaults and the debounce state, counters and toggles return to start.
module button_debounce_event_detector_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  // sample channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_raw_level,
  input  logic [31:0] in_now_ms,
  input  logic        in_clear_presses,
  input  logic        in_clear_releases,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_pressed,
  output logic        out_changed,
  output logic        out_just_pressed,
  output logic        out_just_released,
  output logic        out_double_click,
  output logic        out_held,
  output logic        out_press_toggle,
  output logic        out_release_toggle,
  output logic [15:0] out_press_total,
  output logic [15:0] out_release_total
);

  bdeu_pkg::cfg_t    cfg_r;
  bdeu_pkg::sample_t s1_r;
  logic              s1_valid_r;
  bdeu_pkg::result_t res;
  bdeu_pkg::result_t out_r;
  logic              out_valid_r;
  logic              out_free;
  logic              s1_adv;
  logic              in_acc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level       <= bdeu_pkg::ACTIVE_LEVEL_RST;
      cfg_r.debounce_delay     <= bdeu_pkg::DEBOUNCE_RST;
      cfg_r.double_click_delay <= bdeu_pkg::DOUBLE_CLICK_RST;
      cfg_r.hold_delay         <= bdeu_pkg::HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bdeu_pkg::REG_ACTIVE_LEVEL: cfg_r.active_level       <= cfg_wdata[0];
        bdeu_pkg::REG_DEBOUNCE:     cfg_r.debounce_delay     <= cfg_wdata;
        bdeu_pkg::REG_DOUBLE_CLICK: cfg_r.double_click_delay <= cfg_wdata;
        bdeu_pkg::REG_HOLD:         cfg_r.hold_delay         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: each stage moves when the one after it has room
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.raw_level      <= in_raw_level;
      s1_r.now_ms         <= in_now_ms;
      s1_r.clear_presses  <= in_clear_presses;
      s1_r.clear_releases <= in_clear_releases;
    end
  end

  // Debounce and event logic, state steps as the sample leaves stage one
  bdeu_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .sample  (s1_r),
    .cfg     (cfg_r),
    .result  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_pressed     = out_r.is_pressed;
  assign out_changed        = out_r.changed;
  assign out_just_pressed   = out_r.just_pressed;
  assign out_just_released  = out_r.just_released;
  assign out_double_click   = out_r.double_click;
  assign out_held           = out_r.held;
  assign out_press_toggle   = out_r.press_toggle;
  assign out_release_toggle = out_r.release_toggle;
  assign out_press_total    = out_r.press_total;
  assign out_release_total  = out_r.release_total;

  // Checks
  a_dbl_needs_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.double_click |-> out_r.just_released)
    else $error("double click reported without a release");

  a_held_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.held |-> out_r.is_pressed && !out_r.just_pressed)
    else $error("hold reported while released or on the press itself");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_r))
    else $error("held sample lost or overwritten");

endmodule
